// File: rtl/core/i2cm_pkg.sv
// i2cm_pkg: shared types and codes of the i2c master bit engine
// no dependencies; used by the channel interfaces, the sequencer and the top level

package i2cm_pkg;

    // command codes
    localparam logic [2:0] FUNC_START  = 3'd0;
    localparam logic [2:0] FUNC_STOP   = 3'd1;
    localparam logic [2:0] FUNC_WRITE  = 3'd2;
    localparam logic [2:0] FUNC_READ   = 3'd3;
    localparam logic [2:0] FUNC_GETACK = 3'd4;

    // completion status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BUS_BUSY   = 2'd1;
    localparam logic [1:0] ST_START_FAIL = 2'd2;
    localparam logic [1:0] ST_ACK_TMO    = 2'd3;

    // configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 2'd1;

    // configuration reset values
    localparam logic [15:0] HALF_PERIOD_RST = 16'd250;
    localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd250;

    // one input item (one tick)
    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] func;
        logic [7:0] write_byte;
        logic       send_nack;
        logic       sda_sample;
    } t_in_item;

    // one result item (pin and status view after the tick)
    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive_en;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
        logic [7:0] read_byte;
    } t_out_item;

    // configuration seen by the sequencer
    typedef struct packed {
        logic [15:0] half_period_ticks;
        logic [7:0]  ack_timeout_ticks;
    } t_cfg;

endpackage

// File: rtl/core/i2cm_intf.sv
// i2cm channel interfaces: input items, result items and configuration writes
// depends on i2cm_pkg for the payload types

interface i2cm_in_if;
    logic               valid;
    logic               ready;
    i2cm_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface i2cm_out_if;
    logic                valid;
    logic                ready;
    i2cm_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface i2cm_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [i2cm_pkg::CFG_IDX_W-1:0]      index;
    logic [i2cm_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/i2cm_seq.sv
// i2cm_seq: pin sequencer state and its one-tick next-state logic
// depends on i2cm_pkg; result reflects the state after the current tick

module i2cm_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  i2cm_pkg::t_in_item  i_item,
    input  i2cm_pkg::t_cfg      i_cfg,
    output i2cm_pkg::t_out_item o_result
);
    import i2cm_pkg::*;

    // phase codes
    localparam logic [3:0] PH_IDLE = 4'd0;
    localparam logic [3:0] PH_ST1  = 4'd1;
    localparam logic [3:0] PH_ST2  = 4'd2;
    localparam logic [3:0] PH_SP0  = 4'd3;
    localparam logic [3:0] PH_SP1  = 4'd4;
    localparam logic [3:0] PH_SP2  = 4'd5;
    localparam logic [3:0] PH_WL   = 4'd6;
    localparam logic [3:0] PH_WH   = 4'd7;
    localparam logic [3:0] PH_WT   = 4'd8;
    localparam logic [3:0] PH_RL   = 4'd9;
    localparam logic [3:0] PH_RH   = 4'd10;
    localparam logic [3:0] PH_AL   = 4'd11;
    localparam logic [3:0] PH_AH   = 4'd12;
    localparam logic [3:0] PH_GL   = 4'd13;
    localparam logic [3:0] PH_GH   = 4'd14;
    localparam logic [3:0] PH_GP   = 4'd15;

    logic [3:0]  r_phase,     n_phase;
    logic [3:0]  r_bit_count, n_bit_count;
    logic [15:0] r_delay,     n_delay;
    logic [7:0]  r_poll,      n_poll;
    logic [7:0]  r_shift,     n_shift;
    logic        r_nack,      n_nack;
    logic        r_scl,       n_scl;
    logic        r_sda,       n_sda;
    logic        r_sda_oe,    n_sda_oe;
    logic [1:0]  r_status,    n_status;
    logic [7:0]  r_read_hold, n_read_hold;
    logic        r_done,      n_done;

    logic [15:0] step_ticks;
    logic [15:0] delay_dec;
    logic [3:0]  bit_inc;
    logic        poll_chk;
    logic [7:0]  poll_base;
    logic        sda;

    assign sda        = i_item.sda_sample;
    assign step_ticks = (i_cfg.half_period_ticks == 16'd0) ? 16'd1 : i_cfg.half_period_ticks;
    assign delay_dec  = (r_delay == 16'd0) ? 16'd0 : r_delay - 16'd1;
    assign bit_inc    = r_bit_count + 4'd1;

    // next state for one tick
    always_comb begin
        n_phase     = r_phase;
        n_bit_count = r_bit_count;
        n_delay     = r_delay;
        n_poll      = r_poll;
        n_shift     = r_shift;
        n_nack      = r_nack;
        n_scl       = r_scl;
        n_sda       = r_sda;
        n_sda_oe    = r_sda_oe;
        n_status    = r_status;
        n_read_hold = r_read_hold;
        n_done      = 1'b0;
        poll_chk    = 1'b0;
        poll_base   = r_poll;

        if (r_phase == PH_IDLE) begin
            // idle: take a new command
            if (i_item.cmd_valid) begin
                case (i_item.func)
                    FUNC_START: begin
                        n_sda_oe = 1'b1;
                        n_sda    = 1'b1;
                        n_scl    = 1'b1;
                        n_phase  = PH_ST1;
                        n_delay  = step_ticks;
                    end
                    FUNC_STOP: begin
                        n_sda_oe = 1'b1;
                        n_scl    = 1'b0;
                        n_sda    = 1'b0;
                        n_phase  = PH_SP0;
                        n_delay  = 16'd1;
                    end
                    FUNC_WRITE: begin
                        n_sda_oe    = 1'b1;
                        n_scl       = 1'b0;
                        n_bit_count = 4'd0;
                        n_shift     = i_item.write_byte;
                        n_phase     = PH_WL;
                        n_delay     = step_ticks;
                    end
                    FUNC_READ: begin
                        n_sda_oe    = 1'b0;
                        n_scl       = 1'b0;
                        n_bit_count = 4'd0;
                        n_shift     = 8'd0;
                        n_nack      = i_item.send_nack;
                        n_phase     = PH_RL;
                        n_delay     = step_ticks;
                    end
                    FUNC_GETACK: begin
                        n_sda_oe = 1'b0;
                        n_sda    = 1'b1;
                        n_poll   = 8'd0;
                        n_phase  = PH_GL;
                        n_delay  = step_ticks;
                    end
                    default: begin
                    end
                endcase
            end
        end else if (r_phase == PH_GP) begin
            // acknowledge polling, once per tick
            poll_chk = 1'b1;
        end else begin
            // count down the current step, act at its end
            n_delay = delay_dec;
            if (delay_dec == 16'd0) begin
                case (r_phase)
                    PH_ST1: begin
                        if (!sda) begin
                            n_phase  = PH_IDLE;
                            n_status = ST_BUS_BUSY;
                            n_done   = 1'b1;
                        end else begin
                            n_sda   = 1'b0;
                            n_phase = PH_ST2;
                            n_delay = step_ticks;
                        end
                    end
                    PH_ST2: begin
                        if (sda) begin
                            n_status = ST_START_FAIL;
                        end else begin
                            n_scl    = 1'b0;
                            n_status = ST_OK;
                        end
                        n_phase = PH_IDLE;
                        n_done  = 1'b1;
                    end
                    PH_SP0: begin
                        n_scl   = 1'b1;
                        n_phase = PH_SP1;
                        n_delay = step_ticks;
                    end
                    PH_SP1: begin
                        n_sda   = 1'b1;
                        n_phase = PH_SP2;
                        n_delay = step_ticks;
                    end
                    PH_SP2, PH_WT: begin
                        n_phase  = PH_IDLE;
                        n_status = ST_OK;
                        n_done   = 1'b1;
                    end
                    PH_WL: begin
                        n_sda   = r_shift[7];
                        n_shift = {r_shift[6:0], 1'b0};
                        n_scl   = 1'b1;
                        n_phase = PH_WH;
                        n_delay = step_ticks;
                    end
                    PH_WH: begin
                        n_bit_count = bit_inc;
                        n_scl       = 1'b0;
                        n_phase     = (bit_inc < 4'd8) ? PH_WL : PH_WT;
                        n_delay     = step_ticks;
                    end
                    PH_RL, PH_AL, PH_GL: begin
                        n_scl   = 1'b1;
                        n_phase = (r_phase == PH_RL) ? PH_RH :
                                  (r_phase == PH_AL) ? PH_AH : PH_GH;
                        n_delay = step_ticks;
                    end
                    PH_RH: begin
                        n_shift     = {r_shift[6:0], sda};
                        n_bit_count = bit_inc;
                        n_scl       = 1'b0;
                        n_delay     = step_ticks;
                        if (bit_inc < 4'd8) begin
                            n_phase = PH_RL;
                        end else begin
                            n_sda_oe = 1'b1;
                            n_sda    = r_nack;
                            n_phase  = PH_AL;
                        end
                    end
                    PH_AH: begin
                        n_scl       = 1'b0;
                        n_read_hold = r_shift;
                        n_phase     = PH_IDLE;
                        n_status    = ST_OK;
                        n_done      = 1'b1;
                    end
                    PH_GH: begin
                        n_poll    = 8'd0;
                        poll_base = 8'd0;
                        poll_chk  = 1'b1;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end

        // acknowledge check: low is ack, too many high samples time out
        if (poll_chk) begin
            if (!sda) begin
                n_scl    = 1'b0;
                n_phase  = PH_IDLE;
                n_status = ST_OK;
                n_done   = 1'b1;
            end else if (poll_base >= i_cfg.ack_timeout_ticks) begin
                n_scl    = 1'b0;
                n_phase  = PH_IDLE;
                n_status = ST_ACK_TMO;
                n_done   = 1'b1;
            end else begin
                n_poll  = poll_base + 8'd1;
                n_phase = PH_GP;
            end
        end
    end

    // state registers advance once per accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_bit_count <= 4'd0;
            r_delay     <= 16'd0;
            r_poll      <= 8'd0;
            r_shift     <= 8'd0;
            r_nack      <= 1'b0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_sda_oe    <= 1'b1;
            r_status    <= ST_OK;
            r_read_hold <= 8'd0;
            r_done      <= 1'b0;
        end else if (i_fire) begin
            r_phase     <= n_phase;
            r_bit_count <= n_bit_count;
            r_delay     <= n_delay;
            r_poll      <= n_poll;
            r_shift     <= n_shift;
            r_nack      <= n_nack;
            r_scl       <= n_scl;
            r_sda       <= n_sda;
            r_sda_oe    <= n_sda_oe;
            r_status    <= n_status;
            r_read_hold <= n_read_hold;
            r_done      <= n_done;
        end
    end

    // result of this tick
    always_comb begin
        o_result.scl_level    = n_scl;
        o_result.sda_level    = n_sda;
        o_result.sda_drive_en = n_sda_oe;
        o_result.busy_res     = (n_phase != PH_IDLE);
        o_result.done_res     = n_done;
        o_result.status       = n_status;
        o_result.read_byte    = n_read_hold;
    end

    // a valid command taken while idle always starts a sequence
    a_cmd_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && r_phase == PH_IDLE && i_item.cmd_valid && i_item.func <= FUNC_GETACK)
        |=> (r_phase != PH_IDLE))
        else $error("accepted command did not leave idle");

    // a timed step never sits with an expired counter
    a_delay_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE && r_phase != PH_GP) |-> (r_delay != 16'd0))
        else $error("timed phase with zero delay count");

    // bit counter stays within one byte
    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_count <= 4'd8)
        else $error("bit counter out of range");

    // done is only ever flagged while the sequencer is idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_phase == PH_IDLE))
        else $error("done flagged while a command is in progress");

endmodule

// File: rtl/core/i2c_master_bit_engine_core.sv
// i2c_master_bit_engine_core: top level of the i2c master bit engine
// depends on i2cm_pkg, the i2cm channel interfaces and i2cm_seq
//
//   channel   dir   transfer                         payload
//   i_item    in    one tick: command + sda sample   t_in_item
//   o_res     out   one result per accepted tick     t_out_item
//   i_cfg     in    register write, always ready     index, data
//
// each accepted tick's result is registered in the output register, or in the skid entry
// while a result waits there; a new tick is taken every cycle while i_item.ready is high;
// a two-entry output buffer (register + skid) keeps the input side open while one result
// waits to be taken; i_item.ready drops only while both buffer entries hold results
// synchronous active-low reset: pins high, sda driven, idle, default timing

module i2c_master_bit_engine_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    i2cm_in_if.sink    i_item,
    i2cm_out_if.source o_res,
    i2cm_cfg_if.sink   i_cfg
);
    import i2cm_pkg::*;

    logic        r_out_valid;
    t_out_item   r_out;
    logic        r_skid_valid;
    t_out_item   r_skid;
    t_cfg        r_cfg;
    t_out_item   step_res;
    logic        in_fire;
    logic        out_fire;

    assign i_item.ready = !r_skid_valid;
    assign in_fire      = i_item.valid && i_item.ready;
    assign out_fire     = r_out_valid && o_res.ready;
    assign o_res.valid  = r_out_valid;
    assign o_res.data   = r_out;
    assign i_cfg.ready  = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_period_ticks <= HALF_PERIOD_RST;
            r_cfg.ack_timeout_ticks <= ACK_TIMEOUT_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_HALF_PERIOD: r_cfg.half_period_ticks <= i_cfg.data[15:0];
                CFG_ACK_TIMEOUT: r_cfg.ack_timeout_ticks <= i_cfg.data[7:0];
                default: begin
                end
            endcase
        end
    end

    // pin sequencer
    i2cm_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (in_fire),
        .i_item   (i_item.data),
        .i_cfg    (r_cfg),
        .o_result (step_res)
    );

    // output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_fire) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= in_fire;
            end
        end else if (in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_fire) begin
            r_out <= r_skid_valid ? r_skid : step_res;
        end
        if (in_fire && !r_skid_valid) begin
            r_skid <= step_res;
        end
    end

    // the skid entry is only ever filled behind a waiting result
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds a result with an empty output register");

endmodule

// File: dv/i2c_master_bit_engine_core_tb.sv
// i2c_master_bit_engine_core_tb: self-checking bench for the i2c master bit engine
// depends on i2cm_pkg, the i2cm channel interfaces and i2c_master_bit_engine_core
// command table then random bus transactions, checked against a tick-true model

module i2c_master_bit_engine_core_tb;

    import i2cm_pkg::*;

    // sequencer steps tracked by the model
    typedef enum logic [4:0] {
        SEQ_IDLE, SEQ_START_HI, SEQ_START_LO, SEQ_STOP_SETUP, SEQ_STOP_SCL, SEQ_STOP_SDA,
        SEQ_WR_LOW, SEQ_WR_HIGH, SEQ_WR_TAIL, SEQ_RD_LOW, SEQ_RD_HIGH, SEQ_ANS_LOW,
        SEQ_ANS_HIGH, SEQ_ACK_LOW, SEQ_ACK_HIGH, SEQ_ACK_POLL
    } t_seq;

    // how the sda line behaves while a command runs
    typedef enum logic [1:0] {LINE_FOLLOW, LINE_LOW, LINE_HIGH, LINE_NOISE} t_line;

    // one row of the command table
    typedef struct packed {
        t_in_item  cmd;
        t_line     line;
        logic      typed;
        t_out_item res;
    } t_dir_row;

    // rows from here on run at short timing
    localparam int FAST_ROW = 4;

    localparam t_dir_row DIR_ROWS [20] = '{
        // idle tick right after reset
        '{'{1'b0, FUNC_START, 8'h00, 1'b0, 1'b0}, LINE_FOLLOW, 1'b1,
          '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, ST_OK, 8'h00}},
        // unknown function codes are dropped
        '{'{1'b1, 3'd5, 8'hff, 1'b1, 1'b1}, LINE_FOLLOW, 1'b1,
          '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, ST_OK, 8'h00}},
        '{'{1'b1, 3'd7, 8'h00, 1'b0, 1'b0}, LINE_FOLLOW, 1'b1,
          '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, ST_OK, 8'h00}},
        // start with the bus held low, then with sda stuck high
        '{'{1'b1, FUNC_START, 8'h00, 1'b0, 1'b0}, LINE_LOW, 1'b1,
          '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, ST_BUS_BUSY, 8'h00}},
        '{'{1'b1, FUNC_START, 8'h00, 1'b0, 1'b0}, LINE_HIGH, 1'b1,
          '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, ST_START_FAIL, 8'h00}},
        '{'{1'b1, FUNC_START, 8'h00, 1'b0, 1'b0}, LINE_FOLLOW, 1'b1,
          '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, ST_OK, 8'h00}},
        '{'{1'b1, FUNC_WRITE, 8'hff, 1'b0, 1'b0}, LINE_FOLLOW, 1'b0, '0},
        // acknowledge at once, then never
        '{'{1'b1, FUNC_GETACK, 8'h00, 1'b0, 1'b0}, LINE_LOW, 1'b1,
          '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, ST_OK, 8'h00}},
        '{'{1'b1, FUNC_WRITE, 8'h00, 1'b1, 1'b0}, LINE_FOLLOW, 1'b0, '0},
        '{'{1'b1, FUNC_GETACK, 8'hff, 1'b1, 1'b0}, LINE_HIGH, 1'b1,
          '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, ST_ACK_TMO, 8'h00}},
        '{'{1'b1, FUNC_WRITE, 8'ha5, 1'b0, 1'b0}, LINE_FOLLOW, 1'b0, '0},
        '{'{1'b1, FUNC_GETACK, 8'h00, 1'b0, 1'b0}, LINE_FOLLOW, 1'b0, '0},
        // reads of all ones with nack and all zeros with ack
        '{'{1'b1, FUNC_READ, 8'h00, 1'b1, 1'b0}, LINE_HIGH, 1'b1,
          '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, ST_OK, 8'hff}},
        '{'{1'b1, FUNC_READ, 8'hff, 1'b0, 1'b0}, LINE_LOW, 1'b1,
          '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, ST_OK, 8'h00}},
        '{'{1'b1, FUNC_READ, 8'h3c, 1'b0, 1'b0}, LINE_FOLLOW, 1'b0, '0},
        '{'{1'b1, FUNC_READ, 8'hc3, 1'b1, 1'b0}, LINE_FOLLOW, 1'b0, '0},
        '{'{1'b1, FUNC_WRITE, 8'h5a, 1'b0, 1'b0}, LINE_FOLLOW, 1'b0, '0},
        '{'{1'b1, FUNC_STOP, 8'h00, 1'b0, 1'b0}, LINE_FOLLOW, 1'b0, '0},
        '{'{1'b0, FUNC_WRITE, 8'h81, 1'b1, 1'b1}, LINE_FOLLOW, 1'b0, '0},
        '{'{1'b1, FUNC_STOP, 8'hff, 1'b1, 1'b1}, LINE_FOLLOW, 1'b0, '0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    i2cm_in_if  item_if ();
    i2cm_out_if res_if ();
    i2cm_cfg_if cfg_if ();

    i2c_master_bit_engine_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    always #5 i_clk = ~i_clk;

    // model state and timing registers
    logic [15:0] cfg_half;
    logic [7:0]  cfg_tmo;
    t_seq        seq;
    int          wait_left;
    logic [3:0]  bits_done;
    logic [7:0]  polls;
    logic [7:0]  shifter;
    logic        nack_sel;
    logic        scl_q;
    logic        sda_q;
    logic        oe_q;
    logic [1:0]  status_q;
    logic [7:0]  rd_hold;
    logic        done_q;

    t_out_item   pin_view_q [$];
    t_out_item   typed_res;
    bit          typed_armed;
    bit          no_idle;
    int          items_sent;
    int          mismatch_count;

    // model: enter a delay step
    function automatic void step_to(input t_seq nxt, input int ticks);
        seq       = nxt;
        wait_left = (ticks == 0) ? 1 : ticks;
    endfunction

    function automatic void complete(input logic [1:0] st);
        seq      = SEQ_IDLE;
        status_q = st;
        done_q   = 1'b1;
    endfunction

    // model: one acknowledge poll
    function automatic void ack_check(input logic sda);
        if (!sda) begin
            scl_q = 1'b0;
            complete(ST_OK);
        end else if (polls >= cfg_tmo) begin
            scl_q = 1'b0;
            complete(ST_ACK_TMO);
        end else begin
            polls = polls + 8'd1;
            seq   = SEQ_ACK_POLL;
        end
    endfunction

    // model: pin moves at the end of a delay step
    function automatic void end_of_step(input logic sda);
        int d;
        d = cfg_half;
        case (seq)
            SEQ_START_HI: begin
                if (!sda) begin
                    complete(ST_BUS_BUSY);
                end else begin
                    sda_q = 1'b0;
                    step_to(SEQ_START_LO, d);
                end
            end
            SEQ_START_LO: begin
                if (sda) begin
                    complete(ST_START_FAIL);
                end else begin
                    scl_q = 1'b0;
                    complete(ST_OK);
                end
            end
            SEQ_STOP_SETUP: begin
                scl_q = 1'b1;
                step_to(SEQ_STOP_SCL, d);
            end
            SEQ_STOP_SCL: begin
                sda_q = 1'b1;
                step_to(SEQ_STOP_SDA, d);
            end
            SEQ_WR_LOW: begin
                sda_q   = shifter[7];
                shifter = {shifter[6:0], 1'b0};
                scl_q   = 1'b1;
                step_to(SEQ_WR_HIGH, d);
            end
            SEQ_WR_HIGH: begin
                bits_done = bits_done + 4'd1;
                scl_q     = 1'b0;
                if (bits_done < 4'd8) begin
                    step_to(SEQ_WR_LOW, d);
                end else begin
                    step_to(SEQ_WR_TAIL, d);
                end
            end
            SEQ_STOP_SDA, SEQ_WR_TAIL: begin
                complete(ST_OK);
            end
            SEQ_RD_LOW: begin
                scl_q = 1'b1;
                step_to(SEQ_RD_HIGH, d);
            end
            SEQ_RD_HIGH: begin
                shifter   = {shifter[6:0], sda};
                bits_done = bits_done + 4'd1;
                scl_q     = 1'b0;
                if (bits_done < 4'd8) begin
                    step_to(SEQ_RD_LOW, d);
                end else begin
                    oe_q  = 1'b1;
                    sda_q = nack_sel;
                    step_to(SEQ_ANS_LOW, d);
                end
            end
            SEQ_ANS_LOW: begin
                scl_q = 1'b1;
                step_to(SEQ_ANS_HIGH, d);
            end
            SEQ_ANS_HIGH: begin
                scl_q   = 1'b0;
                rd_hold = shifter;
                complete(ST_OK);
            end
            SEQ_ACK_LOW: begin
                scl_q = 1'b1;
                step_to(SEQ_ACK_HIGH, d);
            end
            SEQ_ACK_HIGH: begin
                polls = 8'd0;
                ack_check(sda);
            end
            default: begin
                seq = SEQ_IDLE;
            end
        endcase
    endfunction

    // model: one tick in, pin and status view out
    function automatic void engine_tick(input t_in_item it, output t_out_item r);
        done_q = 1'b0;
        if (seq == SEQ_IDLE) begin
            if (it.cmd_valid && it.func <= FUNC_GETACK) begin
                case (it.func)
                    FUNC_START: begin
                        oe_q  = 1'b1;
                        sda_q = 1'b1;
                        scl_q = 1'b1;
                        step_to(SEQ_START_HI, cfg_half);
                    end
                    FUNC_STOP: begin
                        oe_q  = 1'b1;
                        scl_q = 1'b0;
                        sda_q = 1'b0;
                        step_to(SEQ_STOP_SETUP, 1);
                    end
                    FUNC_WRITE: begin
                        oe_q      = 1'b1;
                        scl_q     = 1'b0;
                        bits_done = 4'd0;
                        shifter   = it.write_byte;
                        step_to(SEQ_WR_LOW, cfg_half);
                    end
                    FUNC_READ: begin
                        oe_q      = 1'b0;
                        scl_q     = 1'b0;
                        bits_done = 4'd0;
                        shifter   = 8'd0;
                        nack_sel  = it.send_nack;
                        step_to(SEQ_RD_LOW, cfg_half);
                    end
                    default: begin
                        oe_q  = 1'b0;
                        sda_q = 1'b1;
                        polls = 8'd0;
                        step_to(SEQ_ACK_LOW, cfg_half);
                    end
                endcase
            end
        end else if (seq == SEQ_ACK_POLL) begin
            ack_check(it.sda_sample);
        end else begin
            if (wait_left > 0) wait_left--;
            if (wait_left == 0) end_of_step(it.sda_sample);
        end
        r.scl_level    = scl_q;
        r.sda_level    = sda_q;
        r.sda_drive_en = oe_q;
        r.busy_res     = (seq != SEQ_IDLE);
        r.done_res     = done_q;
        r.status       = status_q;
        r.read_byte    = rd_hold;
    endfunction

    // sda level seen on the bus for the coming tick
    function automatic logic line_level(input t_line l);
        case (l)
            LINE_LOW:    return 1'b0;
            LINE_HIGH:   return 1'b1;
            LINE_FOLLOW: return oe_q ? sda_q : 1'($urandom_range(0, 1));
            default:     return 1'($urandom_range(0, 1));
        endcase
    endfunction

    function automatic t_line ack_line();
        return ($urandom_range(99) < 90) ? LINE_FOLLOW : LINE_HIGH;
    endfunction

    function automatic t_in_item make_cmd(input logic [2:0] f, input logic [7:0] wb,
                                          input logic nk);
        t_in_item c;
        c            = '0;
        c.cmd_valid  = 1'b1;
        c.func       = f;
        c.write_byte = wb;
        c.send_nack  = nk;
        return c;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    endtask

    // offer one tick, wait for its transfer, then predict its result
    task automatic send_tick(input t_in_item it);
        t_out_item r;
        while (!no_idle && $urandom_range(99) < 31) begin
            item_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_if.valid <= 1'b1;
        item_if.data  <= it;
        do @(posedge i_clk); while (!item_if.ready);
        items_sent++;
        engine_tick(it, r);
        if (typed_armed && !r.busy_res) begin
            r           = typed_res;
            typed_armed = 1'b0;
        end
        pin_view_q.push_back(r);
    endtask

    // issue one command tick, then keep ticking until the sequencer is idle
    task automatic run_cmd(input t_in_item cmd, input t_line line);
        t_in_item filler;
        cmd.sda_sample = line_level(line);
        send_tick(cmd);
        while (seq != SEQ_IDLE) begin
            // random command bits are dropped while busy
            filler            = t_in_item'($urandom);
            filler.sda_sample = line_level(line);
            send_tick(filler);
        end
    endtask

    // mostly framed bus transactions, some loose commands with a misbehaving line
    task automatic random_traffic(input int count);
        int       target;
        int       k;
        bit       rd;
        t_in_item c;
        target = items_sent + count;
        while (items_sent < target) begin
            if ($urandom_range(99) < 80) begin
                rd = 1'($urandom_range(0, 1));
                k  = $urandom_range(1, 4);
                run_cmd(make_cmd(FUNC_START, 8'($urandom), 1'($urandom)), LINE_FOLLOW);
                run_cmd(make_cmd(FUNC_WRITE, {7'($urandom), rd}, 1'($urandom)), LINE_FOLLOW);
                run_cmd(make_cmd(FUNC_GETACK, 8'($urandom), 1'($urandom)), ack_line());
                for (int j = 0; j < k; j++) begin
                    if (rd) begin
                        run_cmd(make_cmd(FUNC_READ, 8'($urandom), j == k - 1), LINE_FOLLOW);
                    end else begin
                        run_cmd(make_cmd(FUNC_WRITE, 8'($urandom), 1'($urandom)), LINE_FOLLOW);
                        run_cmd(make_cmd(FUNC_GETACK, 8'($urandom), 1'($urandom)), ack_line());
                    end
                end
                run_cmd(make_cmd(FUNC_STOP, 8'($urandom), 1'($urandom)), LINE_FOLLOW);
            end else begin
                c           = t_in_item'($urandom);
                c.cmd_valid = ($urandom_range(99) < 85);
                run_cmd(c, t_line'($urandom_range(0, 3)));
            end
            // a few quiet ticks between transfers of commands
            repeat ($urandom_range(0, 3)) begin
                c           = t_in_item'($urandom);
                c.cmd_valid = 1'b0;
                run_cmd(c, LINE_NOISE);
            end
        end
    endtask

    // both timing registers, written back to back
    task automatic write_cfg(input logic [15:0] half, input logic [7:0] tmo);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= CFG_HALF_PERIOD;
        cfg_if.data  <= half;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_half = half;
        cfg_if.index <= CFG_ACK_TIMEOUT;
        cfg_if.data  <= {8'($urandom), tmo};
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_tmo = tmo;
        cfg_if.valid <= 1'b0;
    endtask

    // stop offering and wait for every predicted result
    task automatic settle();
        item_if.valid <= 1'b0;
        while (pin_view_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // stimulus
    initial begin : stimulus
        logic [15:0] half_sel [3];
        logic [7:0]  tmo_sel [3];
        half_sel = '{16'd1, 16'd0, 16'd2};
        tmo_sel  = '{8'd1, 8'd0, 8'd4};

        cfg_half       = HALF_PERIOD_RST;
        cfg_tmo        = ACK_TIMEOUT_RST;
        seq            = SEQ_IDLE;
        wait_left      = 0;
        bits_done      = 4'd0;
        polls          = 8'd0;
        shifter        = 8'd0;
        nack_sel       = 1'b0;
        scl_q          = 1'b1;
        sda_q          = 1'b1;
        oe_q           = 1'b1;
        status_q       = ST_OK;
        rd_hold        = 8'd0;
        done_q         = 1'b0;
        typed_armed    = 1'b0;
        typed_res      = '0;
        no_idle        = 1'b0;
        items_sent     = 0;
        mismatch_count = 0;

        i_rst_n       <= 1'b0;
        item_if.valid <= 1'b0;
        item_if.data  <= '0;
        cfg_if.valid  <= 1'b0;
        cfg_if.index  <= '0;
        cfg_if.data   <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // command table, reset timing up to the bus busy start, short timing after
        foreach (DIR_ROWS[i]) begin
            if (i == FAST_ROW) begin
                settle();
                write_cfg(16'd1, 8'd3);
            end
            typed_armed = DIR_ROWS[i].typed;
            typed_res   = DIR_ROWS[i].res;
            run_cmd(DIR_ROWS[i].cmd, DIR_ROWS[i].line);
        end
        settle();

        // random traffic over several timing settings, the last one random
        for (int p = 0; p < 4; p++) begin
            if (p == 3) begin
                write_cfg(16'($urandom_range(1, 2)), 8'($urandom_range(0, 7)));
            end else begin
                write_cfg(half_sel[p], tmo_sel[p]);
            end
            no_idle = (p == 2);
            random_traffic(60);
            settle();
        end
        no_idle = 1'b0;

        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // result side: random stalls, one long hold-off, field by field check
    initial begin : result_sink
        int        stall_left;
        int        taken;
        t_out_item got;
        t_out_item want;
        stall_left = 0;
        taken      = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_if.valid && res_if.ready) begin
                got = res_if.data;
                taken++;
                if (taken == 320) stall_left = 300;
                if (pin_view_q.size() == 0) begin
                    report_mismatch("result with nothing expected", 1, 0);
                end else begin
                    want = pin_view_q.pop_front();
                    if (got.scl_level !== want.scl_level)
                        report_mismatch("scl_level", got.scl_level, want.scl_level);
                    if (got.sda_level !== want.sda_level)
                        report_mismatch("sda_level", got.sda_level, want.sda_level);
                    if (got.sda_drive_en !== want.sda_drive_en)
                        report_mismatch("sda_drive_en", got.sda_drive_en, want.sda_drive_en);
                    if (got.busy_res !== want.busy_res)
                        report_mismatch("busy_res", got.busy_res, want.busy_res);
                    if (got.done_res !== want.done_res)
                        report_mismatch("done_res", got.done_res, want.done_res);
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.read_byte !== want.read_byte)
                        report_mismatch("read_byte", got.read_byte, want.read_byte);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= no_idle || ($urandom_range(99) >= 31);
            end
        end
    end

    // watchdog
    initial begin : watchdog
        #40_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
